// ===== hdl/uvst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_pkg
// Shared types, constants and tables of the UV sphere tessellator.
// ----------------------------------------------------------------------------
package uvst_pkg;

  localparam int unsigned DefMaxSectors = 256;
  localparam int unsigned DefMaxStacks  = 256;

  // Counts and grid indexes
  localparam int unsigned CntW  = 9;
  localparam int unsigned IdxW  = 17;
  localparam int unsigned PosW  = 17;
  localparam int unsigned TexW  = 17;
  localparam int unsigned RadW  = 16;

  // Divider: dividend is index << 24, quotient needs 25 bits
  localparam int unsigned DivFrac  = 24;
  localparam int unsigned DvdW     = CntW + DivFrac;
  localparam int unsigned QuoW     = DivFrac + 1;

  // Rotator
  localparam int unsigned CordIters = 20;
  localparam int unsigned CordW     = 34;
  localparam int unsigned AngW      = 26;
  localparam int unsigned TrigW     = 32;
  localparam logic signed [CordW-1:0] CordGain = 34'sd652032874;

  localparam logic signed [PosW+5:0] PosLimit = 23'sd65535;

  localparam int unsigned QDepth = 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SECTORS = 2'd0,
    REG_STACKS  = 2'd1,
    REG_RADIUS  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_TRI    = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  // Back-end sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOADC,
    ST_ROT,
    ST_MUL1,
    ST_MUL2,
    ST_VTX,
    ST_UP,
    ST_LO,
    ST_ERR
  } bk_state_e;

  // Classified grid point waiting for the back end
  typedef struct packed {
    logic            err;
    logic            has_up;
    logic            has_lo;
    logic [CntW-1:0] stack_i;
    logic [CntW-1:0] sector_j;
    logic [CntW-1:0] sectors;
    logic [CntW-1:0] stacks;
    logic [IdxW-1:0] base_k;
  } entry_t;

  // Arctangent table, 2^-24 turn
  function automatic logic signed [AngW-1:0] atan_turn(input logic [4:0] k);
    logic signed [AngW-1:0] v;
    case (k)
      5'd0:  v = 26'sd2097152;
      5'd1:  v = 26'sd1238021;
      5'd2:  v = 26'sd654136;
      5'd3:  v = 26'sd332050;
      5'd4:  v = 26'sd166669;
      5'd5:  v = 26'sd83416;
      5'd6:  v = 26'sd41718;
      5'd7:  v = 26'sd20860;
      5'd8:  v = 26'sd10430;
      5'd9:  v = 26'sd5215;
      5'd10: v = 26'sd2608;
      5'd11: v = 26'sd1304;
      5'd12: v = 26'sd652;
      5'd13: v = 26'sd326;
      5'd14: v = 26'sd163;
      5'd15: v = 26'sd81;
      5'd16: v = 26'sd41;
      5'd17: v = 26'sd20;
      5'd18: v = 26'sd10;
      5'd19: v = 26'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a rounded position to +-65535
  function automatic logic [PosW-1:0] sat_pos(input logic signed [PosW+5:0] v);
    logic [PosW-1:0] r;
    if (v > PosLimit) begin
      r = PosW'(PosLimit);
    end else if (v < -PosLimit) begin
      r = PosW'(-PosLimit);
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/uvst_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_queue
// Short queue of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module uvst_queue
  import uvst_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t mem_q [QDepth];
  logic [$clog2(QDepth)-1:0] wr_q, rd_q;
  logic [$clog2(QDepth+1)-1:0] cnt_q;

  assign full_o  = (cnt_q == ($clog2(QDepth+1))'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/uvst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_front
// Accepts grid points, clamps counts, range-checks and computes vertex index.
// ----------------------------------------------------------------------------
module uvst_front
  import uvst_pkg::*;
#(
  parameter int unsigned MAX_SECTORS = DefMaxSectors,
  parameter int unsigned MAX_STACKS  = DefMaxStacks
) (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [CntW-1:0] stack_index_i,
  input  logic [CntW-1:0] sector_index_i,
  input  logic [CntW-1:0] sector_count_i,
  input  logic [CntW-1:0] stack_count_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output entry_t          q_data_o
);

  logic [CntW-1:0]   s_cnt, t_cnt;
  logic [2*CntW:0]   k_full;
  logic              in_cell;

  // Effective counts: zero acts as one, large values hit the maximum
  always_comb begin
    if (sector_count_i == '0) begin
      s_cnt = CntW'(1);
    end else if (32'(sector_count_i) > MAX_SECTORS) begin
      s_cnt = CntW'(MAX_SECTORS);
    end else begin
      s_cnt = sector_count_i;
    end
    if (stack_count_i == '0) begin
      t_cnt = CntW'(1);
    end else if (32'(stack_count_i) > MAX_STACKS) begin
      t_cnt = CntW'(MAX_STACKS);
    end else begin
      t_cnt = stack_count_i;
    end
  end

  // Vertex index of (i, j): i*(S+1)+j
  assign k_full  = (2*CntW+1)'(stack_index_i * ({1'b0, s_cnt} + 1'b1))
                 + (2*CntW+1)'(sector_index_i);
  assign in_cell = (stack_index_i < t_cnt) && (sector_index_i < s_cnt);

  // Classification
  always_comb begin
    q_data_o.err      = (stack_index_i > t_cnt) || (sector_index_i > s_cnt);
    q_data_o.has_up   = in_cell && (stack_index_i != '0);
    q_data_o.has_lo   = in_cell && (stack_index_i != (t_cnt - 1'b1));
    q_data_o.stack_i  = stack_index_i;
    q_data_o.sector_j = sector_index_i;
    q_data_o.sectors  = s_cnt;
    q_data_o.stacks   = t_cnt;
    q_data_o.base_k   = k_full[IdxW-1:0];
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// ===== hdl/uvst_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_div
// Bit-serial restoring divider: floor(x * 2^24 / d), one bit per step cycle.
// ----------------------------------------------------------------------------
module uvst_div
  import uvst_pkg::*;
(
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            step_i,
  input  logic [CntW-1:0] num_i,
  input  logic [CntW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [DvdW-1:0] dvd_q;
  logic [CntW-1:0] den_q, rem_q;
  logic [QuoW-1:0] quo_q;
  logic [CntW:0]   sh, diff;
  logic            ge;

  // Trial subtract
  assign sh   = {rem_q, dvd_q[DvdW-1]};
  assign ge   = (sh >= {1'b0, den_q});
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= {num_i, {DivFrac{1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (step_i) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= ge ? diff[CntW-1:0] : sh[CntW-1:0];
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== hdl/uvst_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_cordic
// Iterative rotation CORDIC, one micro-rotation per step, Q1.30 cos/sin.
// ----------------------------------------------------------------------------
module uvst_cordic
  import uvst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic                    step_i,
  input  logic [4:0]              iter_i,
  input  logic [23:0]             phase_i,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);

  logic signed [CordW-1:0] x_q, y_q, sx, sy;
  logic signed [AngW-1:0]  z_q, z0, at;
  logic [1:0]              quad_q;
  logic [24:0]             p25;
  logic [2:0]              qq;

  // Reduce to nearest quadrant, residual within +-45 deg
  assign p25 = {1'b0, phase_i} + 25'h200000;
  assign qq  = p25[24:22];
  assign z0  = $signed({2'b00, phase_i}) - $signed({1'b0, qq, 22'b0});

  assign sx = x_q >>> iter_i;
  assign sy = y_q >>> iter_i;
  assign at = atan_turn(iter_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q    <= CordGain;
      y_q    <= '0;
      z_q    <= z0;
      quad_q <= qq[1:0];
    end else if (step_i) begin
      if (!z_q[AngW-1]) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + at;
      end
    end
  end

  // Map back to the full circle
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q[TrigW-1:0];
        sin_o = y_q[TrigW-1:0];
      end
      2'd1: begin
        cos_o = -y_q[TrigW-1:0];
        sin_o = x_q[TrigW-1:0];
      end
      2'd2: begin
        cos_o = -x_q[TrigW-1:0];
        sin_o = -y_q[TrigW-1:0];
      end
      default: begin
        cos_o = y_q[TrigW-1:0];
        sin_o = -x_q[TrigW-1:0];
      end
    endcase
  end

endmodule

// ===== hdl/uvst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_back
// Sequencer: divides, rotates, scales and emits vertex, triangles or error.
// ----------------------------------------------------------------------------
module uvst_back
  import uvst_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  entry_t                 q_head_i,
  output logic                   q_pop_o,
  input  logic [RadW-1:0]        radius_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             item_kind_o,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o,
  output logic signed [PosW-1:0] pos_z_o,
  output logic [TexW-1:0]        tex_u_o,
  output logic [TexW-1:0]        tex_v_o,
  output logic [IdxW-1:0]        corner_a_o,
  output logic [IdxW-1:0]        corner_b_o,
  output logic [IdxW-1:0]        corner_c_o,
  output logic                   last_of_run_o
);

  bk_state_e state_q, state_d;
  entry_t    ent_q;
  logic [5:0] cnt_q, cnt_d;

  logic [QuoW-1:0] q_sec, q_stk;
  logic [23:0]     ph_sec, ph_stk;
  logic signed [TrigW-1:0] cp, sp, ct, st;
  logic [TexW-1:0] tu_q, tv_q;

  logic signed [48:0] pxy_q, pz_q;
  logic signed [49:0] rxy, rz;
  logic signed [27:0] xy;
  logic signed [59:0] px_q, py_q;
  logic signed [60:0] rx, ry;
  logic [PosW-1:0]    z_q;

  logic div_load, div_step, rot_load, rot_step, mul1, mul2;
  logic slot_free, emit;
  logic [IdxW-1:0] n_k, k1, kn, kn1;

  // Emit payload
  logic [1:0]      o_kind;
  logic [PosW-1:0] o_x, o_y, o_z;
  logic [TexW-1:0] o_u, o_v;
  logic [IdxW-1:0] o_a, o_b, o_c;
  logic            o_last;

  assign slot_free = !out_valid_o || !out_stall_i;

  // Units
  uvst_div u_div_sec (
    .clk_i, .load_i(div_load), .step_i(div_step),
    .num_i(q_head_i.sector_j), .den_i(q_head_i.sectors), .quo_o(q_sec)
  );
  uvst_div u_div_stk (
    .clk_i, .load_i(div_load), .step_i(div_step),
    .num_i(q_head_i.stack_i), .den_i(q_head_i.stacks), .quo_o(q_stk)
  );

  assign ph_sec = q_sec[23:0];
  assign ph_stk = 24'h400000 - q_stk[24:1];

  uvst_cordic u_rot_stk (
    .clk_i, .load_i(rot_load), .step_i(rot_step), .iter_i(cnt_q[4:0]),
    .phase_i(ph_stk), .cos_o(cp), .sin_o(sp)
  );
  uvst_cordic u_rot_sec (
    .clk_i, .load_i(rot_load), .step_i(rot_step), .iter_i(cnt_q[4:0]),
    .phase_i(ph_sec), .cos_o(ct), .sin_o(st)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (q_valid_i) begin
          state_d = q_head_i.err ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(DvdW - 1)) begin
          state_d = ST_LOADC;
        end
      end
      ST_LOADC: begin
        cnt_d   = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(CordIters - 1)) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_VTX;
      ST_VTX: begin
        if (slot_free) begin
          state_d = ent_q.has_up ? ST_UP : (ent_q.has_lo ? ST_LO : ST_IDLE);
        end
      end
      ST_UP: begin
        if (slot_free) begin
          state_d = ent_q.has_lo ? ST_LO : ST_IDLE;
        end
      end
      ST_LO, ST_ERR: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Arithmetic for rounding and saturation
  assign rxy = 50'(pxy_q) + 50'sd2097152;
  assign xy  = rxy[49:22];
  assign rz  = 50'(pz_q) + 50'sd536870912;
  assign rx  = 61'(px_q) + (61'sd1 <<< 37);
  assign ry  = 61'(py_q) + (61'sd1 <<< 37);

  // Triangle indexes
  assign n_k = IdxW'(ent_q.sectors) + 1'b1;
  assign k1  = ent_q.base_k + 1'b1;
  assign kn  = ent_q.base_k + n_k;
  assign kn1 = kn + 1'b1;

  // Outputs of the sequencer
  always_comb begin
    q_pop_o  = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    rot_load = 1'b0;
    rot_step = 1'b0;
    mul1     = 1'b0;
    mul2     = 1'b0;
    emit     = 1'b0;
    o_kind   = KIND_VERTEX;
    o_x      = '0;
    o_y      = '0;
    o_z      = '0;
    o_u      = '0;
    o_v      = '0;
    o_a      = '0;
    o_b      = '0;
    o_c      = '0;
    o_last   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        q_pop_o  = q_valid_i;
        div_load = q_valid_i;
      end
      ST_DIV:   div_step = 1'b1;
      ST_LOADC: rot_load = 1'b1;
      ST_ROT:   rot_step = 1'b1;
      ST_MUL1:  mul1 = 1'b1;
      ST_MUL2:  mul2 = 1'b1;
      ST_VTX: begin
        emit   = slot_free;
        o_kind = KIND_VERTEX;
        o_x    = sat_pos(rx[60:38]);
        o_y    = sat_pos(ry[60:38]);
        o_z    = z_q;
        o_u    = tu_q;
        o_v    = tv_q;
        o_last = !ent_q.has_up && !ent_q.has_lo;
      end
      ST_UP: begin
        emit   = slot_free;
        o_kind = KIND_TRI;
        o_a    = ent_q.base_k;
        o_b    = kn;
        o_c    = k1;
        o_last = !ent_q.has_lo;
      end
      ST_LO: begin
        emit   = slot_free;
        o_kind = KIND_TRI;
        o_a    = k1;
        o_b    = kn;
        o_c    = kn1;
        o_last = 1'b1;
      end
      ST_ERR: begin
        emit   = slot_free;
        o_kind = KIND_ERROR;
        o_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_head_i;
    end
    if (rot_load) begin
      tu_q <= q_sec[QuoW-1:8];
      tv_q <= q_stk[QuoW-1:8];
    end
    if (mul1) begin
      pxy_q <= $signed({1'b0, radius_i}) * cp;
      pz_q  <= $signed({1'b0, radius_i}) * sp;
    end
    if (mul2) begin
      px_q <= xy * ct;
      py_q <= xy * st;
      z_q  <= sat_pos((PosW+6)'($signed(rz[49:30])));
    end
    if (emit) begin
      item_kind_o   <= o_kind;
      pos_x_o       <= o_x;
      pos_y_o       <= o_y;
      pos_z_o       <= o_z;
      tex_u_o       <= o_u;
      tex_v_o       <= o_v;
      corner_a_o    <= o_a;
      corner_b_o    <= o_b;
      corner_c_o    <= o_c;
      last_of_run_o <= o_last;
    end
  end

endmodule

// ===== hdl/uv_sphere_tessellator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_tessellator_unit
// UV sphere vertex and index-triangle generator.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one grid point per request:
// stack index i and sector index j. The output channel (out_valid_o /
// out_stall_i) returns the vertex of that point, then up to two triangles;
// last_of_run_o marks the final result. Out-of-range points return one
// error result.
// A two-entry queue decouples intake from the back end, so new requests are
// taken while a result waits. Each vertex runs two bit-serial dividers, a
// load state and two iterative CORDIC rotators, then two multiply stages
// before the vertex, followed by its triangles. The back end takes the next
// grid point from the queue only after the last result of the previous one
// is emitted; throughput is set by the divider and CORDIC iterations.
// Error points skip the arithmetic and return their error result directly.
// Reset clears the queue, the sequencer and the output valid, and loads
// the count and radius registers with 36, 18 and 1.0. A stalled result
// holds its register; the back end waits and the queue fills, after which
// in_stall_o rises. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_unit
  import uvst_pkg::*;
#(
  parameter int unsigned MAX_SECTORS = DefMaxSectors,
  parameter int unsigned MAX_STACKS  = DefMaxStacks
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CntW-1:0]        stack_index_i,
  input  logic [CntW-1:0]        sector_index_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [RadW-1:0]        cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             item_kind_o,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o,
  output logic signed [PosW-1:0] pos_z_o,
  output logic [TexW-1:0]        tex_u_o,
  output logic [TexW-1:0]        tex_v_o,
  output logic [IdxW-1:0]        corner_a_o,
  output logic [IdxW-1:0]        corner_b_o,
  output logic [IdxW-1:0]        corner_c_o,
  output logic                   last_of_run_o
);

  logic [CntW-1:0] sectors_q, stacks_q;
  logic [RadW-1:0] radius_q;
  logic   q_full, q_push, q_valid, q_pop;
  entry_t q_in, q_head;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sectors_q <= CntW'(36);
      stacks_q  <= CntW'(18);
      radius_q  <= RadW'(256);
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SECTORS: sectors_q <= cfg_data_i[CntW-1:0];
        REG_STACKS:  stacks_q  <= cfg_data_i[CntW-1:0];
        REG_RADIUS:  radius_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  uvst_front #(
    .MAX_SECTORS(MAX_SECTORS),
    .MAX_STACKS (MAX_STACKS)
  ) u_front (
    .in_valid_i,
    .in_stall_o,
    .stack_index_i,
    .sector_index_i,
    .sector_count_i(sectors_q),
    .stack_count_i (stacks_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  uvst_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (q_push),
    .push_data_i(q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  uvst_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i(q_valid),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .radius_i (radius_q),
    .out_valid_o,
    .out_stall_i,
    .item_kind_o,
    .pos_x_o,
    .pos_y_o,
    .pos_z_o,
    .tex_u_o,
    .tex_v_o,
    .corner_a_o,
    .corner_b_o,
    .corner_c_o,
    .last_of_run_o
  );

endmodule
